// File: rtl/core/sdk_pkg.sv
// ----------------------------------------------------------------------------
// sdk_pkg
// Shared types and constants for the save word keystream descrambler.
// ----------------------------------------------------------------------------
package sdk_pkg;

    localparam int WORD_W  = 16;
    localparam int TOTAL_W = 32;

    localparam logic [7:0]          KEY_MULT       = 8'hB0;
    localparam logic [WORD_W-1:0]   KEY_MOD        = 16'hFF53;
    // 2^16 mod KEY_MOD, used to fold the upper product bits back in
    localparam logic [7:0]          KEY_FOLD       = 8'hAD;
    // next key after reset: a zero key is forced to 1, and 1 * 0xB0 mod 0xFF53 is 0xB0
    localparam logic [WORD_W-1:0]   KEY_RESET_NEXT = 16'h00B0;

    typedef enum logic [2:0] {
        POS_HDR    = 3'd0,
        POS_SEED   = 3'd1,
        POS_SUM_LO = 3'd2,
        POS_SUM_HI = 3'd3,
        POS_BODY   = 3'd4
    } t_pos;

    typedef struct packed {
        logic load;
        logic step;
        logic clear;
    } t_key_ctrl;

endpackage

// File: rtl/core/sdk_key_gen.sv
// ----------------------------------------------------------------------------
// sdk_key_gen
// Keystream register. Holds the key that the next scrambled word will use,
// so the data path reads it straight from a flop.
// ----------------------------------------------------------------------------
module sdk_key_gen import sdk_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_key_ctrl         i_ctrl,
    input  logic [WORD_W-1:0] i_seed,
    output logic [WORD_W-1:0] o_key
);

    logic [WORD_W-1:0] r_key;
    logic [WORD_W-1:0] n_key;

    // (k ? k : 1) * 0xB0 mod 0xFF53
    function automatic logic [WORD_W-1:0] next_key(input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] k1;
        logic [23:0]       prod;
        logic [16:0]       fold;
        logic [16:0]       red;
        k1   = (k == '0) ? 16'd1 : k;
        prod = 24'(k1) * 24'(KEY_MULT);
        fold = 17'(prod[23:16]) * 17'(KEY_FOLD) + 17'(prod[15:0]);
        red  = (fold >= 17'(KEY_MOD)) ? fold - 17'(KEY_MOD) : fold;
        return red[WORD_W-1:0];
    endfunction

    always_comb begin
        n_key = r_key;
        if (i_ctrl.clear) begin
            n_key = KEY_RESET_NEXT;
        end else if (i_ctrl.load) begin
            n_key = next_key(i_seed);
        end else if (i_ctrl.step) begin
            n_key = next_key(r_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= KEY_RESET_NEXT;
        end else begin
            r_key <= n_key;
        end
    end

    assign o_key = r_key;

endmodule

// File: rtl/core/sdk_track.sv
// ----------------------------------------------------------------------------
// sdk_track
// Word position, descramble and checksum tracking for one beat per cycle while i_fire is high.
// ----------------------------------------------------------------------------
module sdk_track import sdk_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [WORD_W-1:0]  i_word,
    input  logic               i_final,
    input  logic [WORD_W-1:0]  i_key,
    output t_key_ctrl          o_key_ctrl,
    output logic [WORD_W-1:0]  o_word,
    output logic [TOTAL_W-1:0] o_sum_computed,
    output logic [TOTAL_W-1:0] o_sum_stored,
    output logic               o_sum_match
);

    t_pos               r_pos;
    t_pos               n_pos;
    logic [WORD_W-1:0]  r_sum_lo;
    logic [WORD_W-1:0]  r_sum_hi;
    logic [TOTAL_W-1:0] r_total;
    logic [WORD_W-1:0]  n_sum_lo;
    logic [WORD_W-1:0]  n_sum_hi;
    logic [TOTAL_W-1:0] n_total;
    logic [WORD_W-1:0]  res;

    always_comb begin
        res      = i_word;
        n_sum_lo = r_sum_lo;
        n_sum_hi = r_sum_hi;
        n_total  = r_total;
        case (r_pos)
            POS_HDR, POS_SEED: begin
                res = i_word;
            end
            POS_SUM_LO: begin
                res      = i_word ^ i_key;
                n_sum_lo = res;
            end
            POS_SUM_HI: begin
                res      = i_word ^ i_key;
                n_sum_hi = res;
            end
            POS_BODY: begin
                res     = i_word ^ i_key;
                n_total = r_total + TOTAL_W'(res[7:0]) + TOTAL_W'(res[15:8]);
            end
            default: begin
                res = i_word;
            end
        endcase
        n_pos = (r_pos == POS_BODY) ? POS_BODY : t_pos'(r_pos + 3'd1);
    end

    always_comb begin
        o_key_ctrl.load  = i_fire && (r_pos == POS_SEED);
        o_key_ctrl.step  = i_fire && (r_pos == POS_SUM_LO || r_pos == POS_SUM_HI
                                      || r_pos == POS_BODY);
        o_key_ctrl.clear = i_fire && i_final;
    end

    assign o_word         = res;
    assign o_sum_computed = n_total;
    assign o_sum_stored   = {n_sum_hi, n_sum_lo};
    assign o_sum_match    = i_final && (n_total == {n_sum_hi, n_sum_lo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_HDR;
            r_sum_lo <= '0;
            r_sum_hi <= '0;
            r_total  <= '0;
        end else if (i_fire) begin
            if (i_final) begin
                r_pos    <= POS_HDR;
                r_sum_lo <= '0;
                r_sum_hi <= '0;
                r_total  <= '0;
            end else begin
                r_pos    <= n_pos;
                r_sum_lo <= n_sum_lo;
                r_sum_hi <= n_sum_hi;
                r_total  <= n_total;
            end
        end
    end

endmodule

// File: rtl/core/save_word_keystream_descrambler.sv
// ----------------------------------------------------------------------------
// save_word_keystream_descrambler
// Descrambles a save image word by word and checks its byte checksum.
// ----------------------------------------------------------------------------
// Takes one 16-bit word beat per cycle when not stalled and returns one result
// beat per word via the input beat register and the result beat register. Words 0
// and 1 pass through, word 1 seeds the key, later words are XORed with the key
// stream; words 2 and 3 give the stored sum and the bytes of words 4 on are
// summed. The beat flagged final carries both sums and the match flag, and
// the next word starts a new image. The rate is set by the key register loop,
// which computes the following key in the same cycle that a word consumes one.
module save_word_keystream_descrambler import sdk_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [WORD_W-1:0]  i_word_in,
    input  logic               i_final_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [WORD_W-1:0]  o_word_out,
    output logic               o_is_last,
    output logic [TOTAL_W-1:0] o_sum_computed,
    output logic [TOTAL_W-1:0] o_sum_stored,
    output logic               o_sum_match
);

    logic               r_in_valid;
    logic [WORD_W-1:0]  r_in_word;
    logic               r_in_final;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_word;
    logic               r_out_last;
    logic [TOTAL_W-1:0] r_out_computed;
    logic [TOTAL_W-1:0] r_out_stored;
    logic               r_out_match;

    logic               advance;
    t_key_ctrl          key_ctrl;
    logic [WORD_W-1:0]  key;
    logic [WORD_W-1:0]  res_word;
    logic [TOTAL_W-1:0] res_computed;
    logic [TOTAL_W-1:0] res_stored;
    logic               res_match;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    sdk_key_gen u_key_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (key_ctrl),
        .i_seed  (r_in_word),
        .o_key   (key)
    );

    sdk_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (advance),
        .i_word         (r_in_word),
        .i_final        (r_in_final),
        .i_key          (key),
        .o_key_ctrl     (key_ctrl),
        .o_word         (res_word),
        .o_sum_computed (res_computed),
        .o_sum_stored   (res_stored),
        .o_sum_match    (res_match)
    );

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word  <= i_word_in;
            r_in_final <= i_final_word;
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word     <= res_word;
            r_out_last     <= r_in_final;
            r_out_computed <= res_computed;
            r_out_stored   <= res_stored;
            r_out_match    <= res_match;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_word_out     = r_out_word;
    assign o_is_last      = r_out_last;
    assign o_sum_computed = r_out_computed;
    assign o_sum_stored   = r_out_stored;
    assign o_sum_match    = r_out_match;

    a_key_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key < KEY_MOD)
        else $error("key out of range");

    a_match_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sum_match |-> o_is_last)
        else $error("sum match on a beat that is not last");

    a_key_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_final |=> key == KEY_RESET_NEXT)
        else $error("key not restarted after last beat");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("result beat lost");

endmodule

// File: bench/save_word_keystream_descrambler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// save_word_keystream_descrambler_checker
// Watches both channels of the descrambler, predicts and compares each beat.
// ----------------------------------------------------------------------------
// Every accepted input word runs through a local model of the key stream and
// checksum logic. The expected beat is queued, and each accepted output beat
// is compared field by field with the oldest one in the queue.
module save_word_keystream_descrambler_checker import sdk_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [WORD_W-1:0]  i_word_in,
    input  logic               i_final_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [WORD_W-1:0]  i_word_out,
    input  logic               i_is_last,
    input  logic [TOTAL_W-1:0] i_sum_computed,
    input  logic [TOTAL_W-1:0] i_sum_stored,
    input  logic               i_sum_match,
    output int                 o_fail_count,
    output int                 o_pending_beats
);

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic               last;
        logic [TOTAL_W-1:0] computed;
        logic [TOTAL_W-1:0] stored;
        logic               match;
    } t_result_beat;

    t_pos               word_pos;
    logic [WORD_W-1:0]  key_reg;
    logic [WORD_W-1:0]  sum_lo;
    logic [WORD_W-1:0]  sum_hi;
    logic [TOTAL_W-1:0] byte_sum;

    t_result_beat expected_beats[$];
    t_result_beat new_beat;
    t_result_beat want_beat;

    task automatic clear_image();
        word_pos = POS_HDR;
        key_reg  = '0;
        sum_lo   = '0;
        sum_hi   = '0;
        byte_sum = '0;
    endtask

    task automatic descramble_word(input logic [WORD_W-1:0] w, input logic last,
                                   output t_result_beat beat);
        logic [31:0]       k;
        logic [WORD_W-1:0] r;
        r = w;
        if (word_pos == POS_SEED) begin
            key_reg = w;
        end else if (word_pos != POS_HDR) begin
            // a zero key is forced to one before the update
            k = (key_reg == '0) ? 32'd1 : {16'd0, key_reg};
            k = (k * {24'd0, KEY_MULT}) % {16'd0, KEY_MOD};
            key_reg = k[WORD_W-1:0];
            r = w ^ key_reg;
            if (word_pos == POS_SUM_LO) begin
                sum_lo = r;
            end else if (word_pos == POS_SUM_HI) begin
                sum_hi = r;
            end else begin
                byte_sum = byte_sum + {24'd0, r[7:0]} + {24'd0, r[15:8]};
            end
        end
        beat.word     = r;
        beat.last     = last;
        beat.computed = byte_sum;
        beat.stored   = {sum_hi, sum_lo};
        beat.match    = last && (byte_sum == {sum_hi, sum_lo});
        if (word_pos != POS_BODY) word_pos = t_pos'(word_pos + 3'd1);
        if (last) clear_image();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_image();
            expected_beats.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                descramble_word(i_word_in, i_final_word, new_beat);
                expected_beats.push_back(new_beat);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("beat with none expected", {16'd0, i_word_out}, '0);
                end else begin
                    want_beat = expected_beats.pop_front();
                    if (i_word_out !== want_beat.word)
                        report_mismatch("word_out", {16'd0, i_word_out}, {16'd0, want_beat.word});
                    if (i_is_last !== want_beat.last)
                        report_mismatch("is_last", {31'd0, i_is_last}, {31'd0, want_beat.last});
                    if (i_sum_computed !== want_beat.computed)
                        report_mismatch("sum_computed", i_sum_computed, want_beat.computed);
                    if (i_sum_stored !== want_beat.stored)
                        report_mismatch("sum_stored", i_sum_stored, want_beat.stored);
                    if (i_sum_match !== want_beat.match)
                        report_mismatch("sum_match", {31'd0, i_sum_match}, {31'd0, want_beat.match});
                end
            end
        end
        o_pending_beats = expected_beats.size();
    end

endmodule

// File: bench/save_word_keystream_descrambler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// save_word_keystream_descrambler_tb
// Stimulus and verdict for the save word keystream descrambler.
// ----------------------------------------------------------------------------
// Sends a few hand-built images (short images ending early, zero keys, a seed
// that drives the key to zero, an image whose sums match) and then random
// images of random length. Both sides idle at random; once the output is held
// off long enough to back up the input, and once the sender waits for the
// block to drain. The checker beside the block predicts and compares.
module save_word_keystream_descrambler_tb import sdk_pkg::*;;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 850;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [WORD_W-1:0]  word_in = '0;
    logic               final_word = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [WORD_W-1:0]  word_out;
    logic               is_last;
    logic [TOTAL_W-1:0] sum_computed;
    logic [TOTAL_W-1:0] sum_stored;
    logic               sum_match;
    int                 fail_count;
    int                 pending_beats;

    int                 words_sent = 0;
    int                 cycles = 0;
    bit                 tx_calm = 1'b0;
    bit                 hold_request = 1'b0;

    save_word_keystream_descrambler u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_word_in      (word_in),
        .i_final_word   (final_word),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_word_out     (word_out),
        .o_is_last      (is_last),
        .o_sum_computed (sum_computed),
        .o_sum_stored   (sum_stored),
        .o_sum_match    (sum_match)
    );

    save_word_keystream_descrambler_checker u_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_word_in       (word_in),
        .i_final_word    (final_word),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_word_out      (word_out),
        .i_is_last       (is_last),
        .i_sum_computed  (sum_computed),
        .i_sum_stored    (sum_stored),
        .i_sum_match     (sum_match),
        .o_fail_count    (fail_count),
        .o_pending_beats (pending_beats)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles = cycles + 1;
        end
        $display("save_word_keystream_descrambler_tb failed");
        $finish;
    end

    task automatic send_word(input logic [WORD_W-1:0] w, input logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        word_in    <= w;
        final_word <= last;
        do @(posedge clk); while (in_stall);
        words_sent = words_sent + 1;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do @(negedge clk); while (pending_beats != 0);
    endtask

    // output side: random stall per beat, one long hold when asked
    initial begin
        int  n;
        bit  rx_calm;
        rx_calm = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
            n = rx_calm ? 0 : $urandom_range(0, 10);
            if (hold_request) begin
                n = 300;
                hold_request = 1'b0;
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin
        int                r;
        int                len;
        bit                odd_seed;
        bit                hold_done;
        bit                drain_done;
        logic [WORD_W-1:0] w;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // image ending on its header word
        send_word(16'h0000, 1'b1);
        // image ending on the seed
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b1);
        // zero seed, image ending on the low stored half
        send_word(16'h1234, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b1);
        // seed that takes the key to zero, then forced to one
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFF53, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b1);
        // stored and computed sums agree
        send_word(16'hABCD, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h014E, 1'b0);
        send_word(16'h7900, 1'b0);
        send_word(16'h97E8, 1'b1);
        // body words at both extremes
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b1);

        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                len = $urandom_range(1, 4);
            end else if (r < 95) begin
                len = $urandom_range(5, 24);
            end else begin
                len = $urandom_range(30, 60);
            end
            tx_calm  = ($urandom_range(0, 3) == 0);
            odd_seed = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
                w = WORD_W'($urandom_range(0, 65535));
                if (i == 1 && odd_seed) w = $urandom_range(0, 1) ? 16'hFF53 : 16'h0000;
                send_word(w, i == len - 1);
            end
            if (!hold_done && words_sent >= 300) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && words_sent >= 600) begin
                in_valid <= 1'b0;
                wait_drained();
                drain_done = 1'b1;
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("save_word_keystream_descrambler_tb passed");
        end else begin
            $display("save_word_keystream_descrambler_tb failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sdk_pkg.sv
rtl/core/sdk_key_gen.sv
rtl/core/sdk_track.sv
rtl/core/save_word_keystream_descrambler.sv
bench/save_word_keystream_descrambler_checker.sv
bench/save_word_keystream_descrambler_tb.sv
